// ===== rtl/core/mmf_pkg.sv =====
// Shared types and constants for the multimodal mode finder.
// Used by mmf_cmp_unit and multimodal_mode_finder; depends on nothing.

package mmf_pkg;

   localparam int SAMPLE_W      = 32;
   localparam int OCC_W         = 7;
   localparam int OCC_MAX       = 127;
   localparam int MAX_ITEMS_DEF = 64;
   localparam int MAX_RESULTS   = 64;
   localparam int EMIT_W        = $clog2(MAX_RESULTS + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_res_type;

endpackage

// ===== rtl/core/mmf_cmp_unit.sv =====
// Shared signed compare unit of the mode finder sequencer.
// Depends on mmf_pkg.

module mmf_cmp_unit (
   input  mmf_pkg::sample_type  a,
   input  mmf_pkg::sample_type  b,
   output mmf_pkg::cmp_res_type res
);

   assign res.eq = (a == b);
   assign res.lt = (a < b);

endmodule

// ===== rtl/core/multimodal_mode_finder.sv =====
// Top level of the multimodal mode finder: sample store, count store and sequencer.
// Depends on mmf_pkg and mmf_cmp_unit.
//
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    req_sample, req_final_item
//  rsp      out  rsp_valid/rsp_ready    rsp_mode_value, rsp_occurrences,
//                                       rsp_last_mode, rsp_overflowed
//
// Samples load one request per cycle while the block is in its load state.
// After the closing request, the count pass compares each of the n stored samples
// with every stored sample, one compare at a time through the single store read
// port; each selection scan then reads all n samples, one scan per mode plus one.
// Each result holds until taken; req_ready stays low from the closing request
// until the last result of the set is taken. Reset is synchronous and empties the set.

module multimodal_mode_finder #(
   parameter int MAX_ITEMS = mmf_pkg::MAX_ITEMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [mmf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_final_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [mmf_pkg::SAMPLE_W-1:0] rsp_mode_value,
   output logic [mmf_pkg::OCC_W-1:0]     rsp_occurrences,
   output logic                          rsp_last_mode,
   output logic                          rsp_overflowed
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int XW = (CW > mmf_pkg::OCC_W) ? CW : mmf_pkg::OCC_W;
   localparam int EW = mmf_pkg::EMIT_W;

   typedef enum logic [3:0] {
      S_LOAD,
      S_KEY_RD,
      S_KEY,
      S_CNT_RD,
      S_CNT_CMP,
      S_CNT_WR,
      S_SEL_START,
      S_SEL_RD,
      S_SEL_A,
      S_SEL_B,
      S_SEL_END,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]       fill_ff, fill_in;
   logic                ovf_ff, ovf_in;
   logic [CW-1:0]       outer_ff, outer_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       best_ff, best_in;
   logic                cand_ff, cand_in;
   logic                have_min_ff, have_min_in;
   logic                have_pend_ff, have_pend_in;
   logic [EW-1:0]       emitted_ff, emitted_in;
   mmf_pkg::sample_type key_ff, key_in;
   mmf_pkg::sample_type min_ff, min_in;
   mmf_pkg::sample_type pend_ff, pend_in;
   mmf_pkg::sample_type rsp_value_ff, rsp_value_in;
   logic [mmf_pkg::OCC_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   mmf_pkg::sample_type store_mem [MAX_ITEMS];
   logic [CW-1:0]       cnt_mem [MAX_ITEMS];
   mmf_pkg::sample_type rdata_ff;
   logic [CW-1:0]       cdata_ff;
   logic                st_we, cnt_we;
   logic [AW-1:0]       rd_addr;

   mmf_pkg::sample_type  cmp_a, cmp_b;
   mmf_pkg::cmp_res_type cmp_res;
   logic [XW-1:0]        best_x;
   logic [mmf_pkg::OCC_W-1:0] occ_sat;

   mmf_cmp_unit u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp_res)
   );

   assign req_ready       = (state_ff == S_LOAD);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_mode_value  = rsp_value_ff;
   assign rsp_occurrences = rsp_occ_ff;
   assign rsp_last_mode   = rsp_last_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

   assign best_x  = XW'(best_ff);
   assign occ_sat = (best_x > XW'(mmf_pkg::OCC_MAX)) ? mmf_pkg::OCC_W'(mmf_pkg::OCC_MAX)
                                                     : best_x[mmf_pkg::OCC_W-1:0];

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[fill_ff[AW-1:0]] <= req_sample;
      end
      if (cnt_we) begin
         cnt_mem[outer_ff[AW-1:0]] <= cnt_ff;
      end
      rdata_ff <= store_mem[rd_addr];
      cdata_ff <= cnt_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      outer_in     = outer_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      best_in      = best_ff;
      cand_in      = cand_ff;
      have_min_in  = have_min_ff;
      have_pend_in = have_pend_ff;
      emitted_in   = emitted_ff;
      key_in       = key_ff;
      min_in       = min_ff;
      pend_in      = pend_ff;
      rsp_value_in = rsp_value_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      st_we        = 1'b0;
      cnt_we       = 1'b0;
      rd_addr      = idx_ff[AW-1:0];
      cmp_a        = key_ff;
      cmp_b        = rdata_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (fill_ff < CW'(MAX_ITEMS)) begin
                  st_we   = 1'b1;
                  fill_in = fill_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_final_item) begin
                  outer_in     = '0;
                  best_in      = '0;
                  have_pend_in = 1'b0;
                  emitted_in   = '0;
                  state_in     = S_KEY_RD;
               end
            end
         end
         S_KEY_RD: begin
            rd_addr  = outer_ff[AW-1:0];
            state_in = S_KEY;
         end
         S_KEY: begin
            key_in   = rdata_ff;
            idx_in   = '0;
            cnt_in   = '0;
            state_in = S_CNT_RD;
         end
         S_CNT_RD: begin
            state_in = S_CNT_CMP;
         end
         S_CNT_CMP: begin
            if (cmp_res.eq) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (idx_ff + CW'(1) == fill_ff) begin
               state_in = S_CNT_WR;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_CNT_RD;
            end
         end
         S_CNT_WR: begin
            cnt_we = 1'b1;
            if (cnt_ff > best_ff) begin
               best_in = cnt_ff;
            end
            if (outer_ff + CW'(1) == fill_ff) begin
               state_in = S_SEL_START;
            end else begin
               outer_in = outer_ff + CW'(1);
               state_in = S_KEY_RD;
            end
         end
         S_SEL_START: begin
            idx_in      = '0;
            have_min_in = 1'b0;
            state_in    = S_SEL_RD;
         end
         S_SEL_RD: begin
            state_in = S_SEL_A;
         end
         S_SEL_A: begin
            cmp_a    = pend_ff;
            cmp_b    = rdata_ff;
            cand_in  = (cdata_ff == best_ff) && (!have_pend_ff || cmp_res.lt);
            state_in = S_SEL_B;
         end
         S_SEL_B: begin
            cmp_a = rdata_ff;
            cmp_b = min_ff;
            if (cand_ff && (!have_min_ff || cmp_res.lt)) begin
               min_in      = rdata_ff;
               have_min_in = 1'b1;
            end
            if (idx_ff + CW'(1) == fill_ff) begin
               state_in = S_SEL_END;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SEL_RD;
            end
         end
         S_SEL_END: begin
            if (have_min_ff && !have_pend_ff) begin
               pend_in      = min_ff;
               have_pend_in = 1'b1;
               state_in     = S_SEL_START;
            end else begin
               rsp_value_in = pend_ff;
               rsp_occ_in   = occ_sat;
               rsp_last_in  = !have_min_ff || (emitted_ff == EW'(mmf_pkg::MAX_RESULTS - 1));
               rsp_ovf_in   = ovf_ff;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               emitted_in = emitted_ff + EW'(1);
               if (rsp_last_ff) begin
                  fill_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  pend_in  = min_ff;
                  state_in = S_SEL_START;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         have_min_ff  <= 1'b0;
         have_pend_ff <= 1'b0;
         emitted_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         have_min_ff  <= have_min_in;
         have_pend_ff <= have_pend_in;
         emitted_ff   <= emitted_in;
      end
      outer_ff     <= outer_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      best_ff      <= best_in;
      cand_ff      <= cand_in;
      key_ff       <= key_in;
      min_ff       <= min_in;
      pend_ff      <= pend_in;
      rsp_value_ff <= rsp_value_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule

// ===== verif/multimodal_mode_finder_test.sv =====
// Self-checking testbench for multimodal_mode_finder: directed table, then random sample sets.
// Predicts the mode reports of each set in-bench; depends on mmf_pkg and the RTL top level.

module multimodal_mode_finder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH  = mmf_pkg::MAX_ITEMS_DEF;
   localparam int RANDOM_ITEMS = 220;
   localparam int STALL_LIMIT  = 60000;
   localparam int DRAIN_CYCLES = 300;
   localparam int DIRECTED_ROWS = 19;

   localparam mmf_pkg::sample_type SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam mmf_pkg::sample_type SAMPLE_MIN = 32'sh8000_0000;

   typedef logic [mmf_pkg::OCC_W-1:0] occ_type;

   typedef struct packed {
      mmf_pkg::sample_type mode_value;
      occ_type             occurrences;
      logic                last_mode;
      logic                overflowed;
   } mode_report_type;

   typedef struct packed {
      mmf_pkg::sample_type sample;
      logic                final_item;
      logic                typed;
      mmf_pkg::sample_type want_value;
      occ_type             want_occ;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   mmf_pkg::sample_type req_sample = '0;
   logic                req_final_item = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   mmf_pkg::sample_type rsp_mode_value;
   occ_type             rsp_occurrences;
   logic                rsp_last_mode;
   logic                rsp_overflowed;

   mode_report_type pending_reports [$];
   mode_report_type predicted [mmf_pkg::MAX_RESULTS];
   int              predicted_count;

   mmf_pkg::sample_type stored_samples [STORE_DEPTH];
   int                  fill_count = 0;
   logic                overflow_seen = 1'b0;

   mmf_pkg::sample_type value_pool [4];
   int         pool_size = 1;
   bit         quiet = 1'b0;
   int         error_count = 0;
   int         stall_cycles = 0;

   stim_row_type directed_rows [DIRECTED_ROWS];

   multimodal_mode_finder #(.MAX_ITEMS(STORE_DEPTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_final_item  (req_final_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mode_value  (rsp_mode_value),
      .rsp_occurrences (rsp_occurrences),
      .rsp_last_mode   (rsp_last_mode),
      .rsp_overflowed  (rsp_overflowed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic queue_report(input mode_report_type rpt);
      pending_reports.insert(pending_reports.size(), rpt);
   endtask

   task automatic predict_modes(input mmf_pkg::sample_type value, input logic fin);
      mmf_pkg::sample_type keys [STORE_DEPTH];
      mmf_pkg::sample_type key;
      mode_report_type     rpt;
      int                  n, i, j, best;
      predicted_count = 0;
      if (fill_count < STORE_DEPTH) begin
         stored_samples[fill_count] = value;
         fill_count++;
      end else begin
         overflow_seen = 1'b1;
      end
      if (!fin) return;
      n = fill_count;
      for (i = 0; i < n; i++) keys[i] = stored_samples[i];
      for (i = 1; i < n; i++) begin
         key = keys[i];
         j = i;
         while (j > 0 && keys[j-1] > key) begin
            keys[j] = keys[j-1];
            j--;
         end
         keys[j] = key;
      end
      best = 0;
      i = 0;
      while (i < n) begin
         j = i + 1;
         while (j < n && keys[j] == keys[i]) j++;
         if (j - i > best) best = j - i;
         i = j;
      end
      i = 0;
      while (i < n && predicted_count < mmf_pkg::MAX_RESULTS) begin
         j = i + 1;
         while (j < n && keys[j] == keys[i]) j++;
         if (j - i == best) begin
            rpt.mode_value  = keys[i];
            rpt.occurrences = occ_type'(best > mmf_pkg::OCC_MAX ? mmf_pkg::OCC_MAX : best);
            rpt.last_mode   = 1'b0;
            rpt.overflowed  = overflow_seen;
            predicted[predicted_count] = rpt;
            predicted_count++;
         end
         i = j;
      end
      if (predicted_count > 0) predicted[predicted_count-1].last_mode = 1'b1;
      fill_count = 0;
      overflow_seen = 1'b0;
   endtask

   task automatic send_request(input mmf_pkg::sample_type value, input logic fin,
                               input logic typed, input mmf_pkg::sample_type want_value,
                               input occ_type want_occ);
      int              gap, k;
      mode_report_type rpt;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_sample     <= value;
      req_final_item <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_modes(value, fin);
      if (typed) begin
         rpt = '{want_value, want_occ, 1'b1, 1'b0};
         queue_report(rpt);
      end else begin
         for (k = 0; k < predicted_count; k++) queue_report(predicted[k]);
      end
      @(negedge clock);
   endtask

   task automatic hold_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   function automatic mmf_pkg::sample_type pick_extreme();
      case ($urandom_range(0, 3))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return '0;
         default: return -1;
      endcase
   endfunction

   function automatic mmf_pkg::sample_type draw_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return value_pool[$urandom_range(0, pool_size - 1)];
      if (r == 6) return pick_extreme();
      return mmf_pkg::sample_type'($urandom);
   endfunction

   initial begin : rsp_side
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : check_reports
      mode_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected result: mode_value %0d", rsp_mode_value);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_mode_value !== want.mode_value) begin
               $error("mode_value: expected %0d, got %0d", want.mode_value, rsp_mode_value);
               error_count++;
            end
            if (rsp_occurrences !== want.occurrences) begin
               $error("occurrences: expected %0d, got %0d", want.occurrences, rsp_occurrences);
               error_count++;
            end
            if (rsp_last_mode !== want.last_mode) begin
               $error("last_mode: expected %0b, got %0b", want.last_mode, rsp_last_mode);
               error_count++;
            end
            if (rsp_overflowed !== want.overflowed) begin
               $error("overflowed: expected %0b, got %0b", want.overflowed, rsp_overflowed);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : req_side
      int                  r, k, p, set_no, set_len, items_sent;
      bit                  distinct;
      mmf_pkg::sample_type value;
      directed_rows = '{
         '{SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX, 7'd1},
         '{SAMPLE_MIN, 1'b1, 1'b1, SAMPLE_MIN, 7'd1},
         '{32'sd0, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{32'sd0, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{32'sd0, 1'b1, 1'b1, 32'sd0, 7'd3},
         '{SAMPLE_MAX, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{SAMPLE_MIN, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{-32'sd1, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{32'sd0, 1'b1, 1'b0, 32'sd0, 7'd0},
         '{32'sd5, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{-32'sd5, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{32'sd5, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{-32'sd5, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{32'sd1, 1'b1, 1'b0, 32'sd0, 7'd0},
         '{32'sd1, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{-32'sd1, 1'b1, 1'b0, 32'sd0, 7'd0},
         '{32'sh0001_0000, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{32'sh0001_0000, 1'b0, 1'b0, 32'sd0, 7'd0},
         '{32'shFFFF_0000, 1'b1, 1'b1, 32'sh0001_0000, 7'd2}
      };
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (r = 0; r < DIRECTED_ROWS; r++)
         send_request(directed_rows[r].sample, directed_rows[r].final_item,
                      directed_rows[r].typed, directed_rows[r].want_value,
                      directed_rows[r].want_occ);
      hold_for_results();

      set_no = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) hold_for_results();
         quiet = ($urandom_range(0, 3) == 0);
         if (set_no == 3) set_len = STORE_DEPTH + $urandom_range(1, 6);
         else if (set_no == 8) set_len = STORE_DEPTH;
         else set_len = $urandom_range(1, 12);
         distinct = (set_len >= STORE_DEPTH) ? ($urandom_range(0, 1) == 1)
                                             : ($urandom_range(0, 3) == 0);
         pool_size = $urandom_range(1, 4);
         for (p = 0; p < 4; p++)
            value_pool[p] = ($urandom_range(0, 4) == 0) ? pick_extreme()
                                                        : mmf_pkg::sample_type'($urandom);
         for (k = 0; k < set_len; k++) begin
            value = distinct ? mmf_pkg::sample_type'($urandom) : draw_sample();
            send_request(value, k == set_len - 1, 1'b0, '0, '0);
            items_sent++;
         end
         set_no++;
      end

      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
